### hw/rtl/sbpr_pkg.sv
`timescale 1ns / 1ps
// shared types and codes for the serial boot packet receiver
// no dependencies

package sbpr_pkg;

    localparam int BYTE_W = 8;

    // input word kinds
    typedef enum logic [1:0] {
        KIND_RX_BYTE = 2'd0,
        KIND_TIMEOUT = 2'd1,
        KIND_ARM_ACK = 2'd2,
        KIND_ARM_RX  = 2'd3
    } kind_t;

    // receive phases
    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_ACK       = 3'd1,
        PH_SIZE      = 3'd2,
        PH_CHECK     = 3'd3,
        PH_DATA      = 3'd4,
        PH_CHECK_BAD = 3'd5
    } phase_t;

    // completion status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NACKED    = 3'd1,
        ST_TIMEOUT   = 3'd2,
        ST_UNEXPECT  = 3'd3,
        ST_TOO_LARGE = 3'd4,
        ST_MISMATCH  = 3'd5
    } status_t;

    // configuration register indexes
    localparam logic REG_ACK_CODE  = 1'b0;
    localparam logic REG_NACK_CODE = 1'b1;

    // reset values of the code registers
    localparam logic [BYTE_W-1:0] ACK_CODE_RST  = 8'hCC;
    localparam logic [BYTE_W-1:0] NACK_CODE_RST = 8'h33;

    // header byte overhead: size byte counts itself and the checksum
    localparam logic [BYTE_W-1:0] SIZE_OVERHEAD = 8'd2;
    localparam logic [BYTE_W-1:0] FILL_BYTE     = 8'h00;

    // one result word
    typedef struct packed {
        logic              data_valid;
        logic [BYTE_W-1:0] data_byte;
        logic              reply_valid;
        logic [BYTE_W-1:0] reply_byte;
        logic              done_res;
        status_t           status;
        logic [BYTE_W-1:0] data_length;
    } result_t;

endpackage

### hw/rtl/serial_boot_packet_receiver_top.sv
`timescale 1ns / 1ps
// serial boot packet receiver: results are registered before out_valid
// one input word per cycle while in_stall is low; a two-entry output buffer
// (result plus skid register) lets a word enter while a result waits downstream
// rst_n clears phase, counters, sums and output valids; code registers reset
// to 0xCC (ack) and 0x33 (nack)
// depends on sbpr_pkg

module serial_boot_packet_receiver_top
    import sbpr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration
    input  logic              cfg_wr_en,
    input  logic              cfg_index,
    input  logic [BYTE_W-1:0] cfg_data,
    // input channel
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        kind,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic [BYTE_W-1:0] max_len,
    // output channel
    output logic              out_valid,
    input  logic              out_stall,
    output logic              data_valid,
    output logic [BYTE_W-1:0] data_byte,
    output logic              reply_valid,
    output logic [BYTE_W-1:0] reply_byte,
    output logic              done_res,
    output logic [2:0]        status,
    output logic [BYTE_W-1:0] data_length
);

    logic [BYTE_W-1:0] ack_code_reg;
    logic [BYTE_W-1:0] nack_code_reg;

    phase_t            phase_reg,         phase_next;
    logic [BYTE_W-1:0] length_limit_reg,  length_limit_next;
    logic [BYTE_W-1:0] bytes_left_reg,    bytes_left_next;
    logic [BYTE_W-1:0] packet_length_reg, packet_length_next;
    logic [BYTE_W-1:0] expected_sum_reg,  expected_sum_next;
    logic [BYTE_W-1:0] running_sum_reg,   running_sum_next;

    logic              out_valid_reg;
    result_t           out_reg;
    logic              skid_valid_reg;
    result_t           skid_reg;

    logic              in_accept;
    logic              out_pop;
    logic              res_push;
    result_t           res;
    kind_t             in_kind;
    logic [BYTE_W-1:0] size_len;
    logic [BYTE_W-1:0] sum_close;
    logic [BYTE_W-1:0] exp_close;
    logic              close_pkt;
    logic              good;

    assign in_kind   = kind_t'(kind);
    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !skid_valid_reg;
    assign out_pop   = out_valid_reg && !out_stall;
    assign size_len  = rx_byte - SIZE_OVERHEAD;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_code_reg  <= ACK_CODE_RST;
            nack_code_reg <= NACK_CODE_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_ACK_CODE:  ack_code_reg  <= cfg_data;
                REG_NACK_CODE: nack_code_reg <= cfg_data;
                default:       ack_code_reg  <= ack_code_reg;
            endcase
        end
    end

    // next state and result for the accepted word
    always_comb
    begin
        phase_next         = phase_reg;
        length_limit_next  = length_limit_reg;
        bytes_left_next    = bytes_left_reg;
        packet_length_next = packet_length_reg;
        expected_sum_next  = expected_sum_reg;
        running_sum_next   = running_sum_reg;
        res                = '0;
        res_push           = 1'b0;
        close_pkt          = 1'b0;
        sum_close          = running_sum_reg;
        exp_close          = expected_sum_reg;
        good               = 1'b0;

        if (in_accept)
        begin
            case (in_kind)
                KIND_ARM_ACK:
                begin
                    phase_next = PH_ACK;
                end
                KIND_ARM_RX:
                begin
                    phase_next         = PH_SIZE;
                    length_limit_next  = max_len;
                    bytes_left_next    = '0;
                    packet_length_next = '0;
                    expected_sum_next  = '0;
                    running_sum_next   = '0;
                end
                KIND_TIMEOUT:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        res_push     = 1'b1;
                        res.done_res = 1'b1;
                        res.status   = ST_TIMEOUT;
                        phase_next   = PH_IDLE;
                    end
                end
                default:
                begin
                    case (phase_reg)
                        PH_IDLE:
                        begin
                            phase_next = PH_IDLE;
                        end
                        PH_ACK:
                        begin
                            if (rx_byte != FILL_BYTE)
                            begin
                                res_push     = 1'b1;
                                res.done_res = 1'b1;
                                phase_next   = PH_IDLE;
                                if (rx_byte == ack_code_reg)
                                    res.status = ST_OK;
                                else if (rx_byte == nack_code_reg)
                                    res.status = ST_NACKED;
                                else
                                    res.status = ST_UNEXPECT;
                            end
                        end
                        PH_SIZE:
                        begin
                            if (rx_byte != FILL_BYTE)
                            begin
                                if (rx_byte < SIZE_OVERHEAD || size_len > length_limit_reg)
                                begin
                                    phase_next = PH_CHECK_BAD;
                                end
                                else
                                begin
                                    packet_length_next = size_len;
                                    bytes_left_next    = size_len;
                                    running_sum_next   = '0;
                                    phase_next         = PH_CHECK;
                                end
                            end
                        end
                        PH_CHECK_BAD:
                        begin
                            res_push     = 1'b1;
                            res.done_res = 1'b1;
                            res.status   = ST_TOO_LARGE;
                            phase_next   = PH_IDLE;
                        end
                        PH_CHECK:
                        begin
                            expected_sum_next = rx_byte;
                            if (bytes_left_reg == '0)
                            begin
                                close_pkt = 1'b1;
                                sum_close = running_sum_reg;
                                exp_close = rx_byte;
                            end
                            else
                            begin
                                phase_next = PH_DATA;
                            end
                        end
                        PH_DATA:
                        begin
                            res_push         = 1'b1;
                            res.data_valid   = 1'b1;
                            res.data_byte    = rx_byte;
                            running_sum_next = running_sum_reg + rx_byte;
                            bytes_left_next  = bytes_left_reg - 1'b1;
                            if (bytes_left_next == '0)
                            begin
                                close_pkt = 1'b1;
                                sum_close = running_sum_next;
                                exp_close = expected_sum_reg;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
            endcase
        end

        // checksum compare and reply at the end of a packet
        if (close_pkt)
        begin
            good            = (sum_close == exp_close);
            res_push        = 1'b1;
            res.reply_valid = 1'b1;
            res.reply_byte  = good ? ack_code_reg : nack_code_reg;
            res.done_res    = 1'b1;
            res.status      = good ? ST_OK : ST_MISMATCH;
            res.data_length = good ? packet_length_reg : '0;
            phase_next      = PH_IDLE;
        end
    end

    // receive state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            length_limit_reg  <= '0;
            bytes_left_reg    <= '0;
            packet_length_reg <= '0;
            expected_sum_reg  <= '0;
            running_sum_reg   <= '0;
        end
        else
        begin
            phase_reg         <= phase_next;
            length_limit_reg  <= length_limit_next;
            bytes_left_reg    <= bytes_left_next;
            packet_length_reg <= packet_length_next;
            expected_sum_reg  <= expected_sum_next;
            running_sum_reg   <= running_sum_next;
        end
    end

    // output and skid valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_pop)
                skid_valid_reg <= 1'b0;
        end
        else if (res_push)
        begin
            if (out_valid_reg && !out_pop)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (out_pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output and skid words
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_pop)
                out_reg <= skid_reg;
        end
        else if (res_push)
        begin
            if (out_valid_reg && !out_pop)
                skid_reg <= res;
            else
                out_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign data_valid  = out_reg.data_valid;
    assign data_byte   = out_reg.data_byte;
    assign reply_valid = out_reg.reply_valid;
    assign reply_byte  = out_reg.reply_byte;
    assign done_res    = out_reg.done_res;
    assign status      = out_reg.status;
    assign data_length = out_reg.data_length;

    // skid entry is only used behind a full output register
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output register empty");

    // data phase always has bytes to go
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (bytes_left_reg != '0))
        else $error("data phase with no bytes left");

    // a reply only comes with a finished packet
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.reply_valid) |-> out_reg.done_res)
        else $error("reply without done");

    // nonzero length only on a good finished packet
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.data_length != '0)
            |-> (out_reg.done_res && out_reg.status == ST_OK && out_reg.reply_valid))
        else $error("data length reported outside a good packet");

    // a finished transaction leaves the block idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res.done_res) |=> (phase_reg == PH_IDLE))
        else $error("phase not idle after done");

endmodule
